[design/tcpg_pkg.sv]
`default_nettype none

package tcpg_pkg;

    // Card geometry.
    localparam int CenterX   = 160;
    localparam int CenterY   = 120;
    localparam int Radius    = 110;
    localparam int Tile      = 18;
    localparam int GridLeft  = 7;
    localparam int GridRight = 313;
    localparam int GridTop   = 3;
    localparam int GridBot   = 237;

    localparam int XW = 9;
    localparam int YW = 8;
    localparam int CW = 5;
    localparam int RGBW = 24;

    localparam logic [17:0] RADIUS_SQ = 18'(Radius * Radius);

    // Offsets that move the grid origin two tiles away from zero.
    localparam logic [9:0] CX_OFFSET = 10'(2 * Tile - GridLeft);
    localparam logic [8:0] CY_OFFSET = 9'(2 * Tile - GridTop);

    // Reciprocal multipliers for the constant divisions.
    localparam logic [11:0] RECIP_18 = 12'd3641;   // 2^16 / 18, rounded up
    localparam logic [11:0] RECIP_25 = 12'd2622;   // 2^16 / 25, rounded up
    localparam logic [9:0]  RECIP_3  = 10'd683;    // 2^11 / 3, rounded up

    // Horizontal grid row boundaries: GridTop + n * Tile.
    localparam logic [7:0] ROW_1  = 8'(GridTop + 1 * Tile);
    localparam logic [7:0] ROW_2  = 8'(GridTop + 2 * Tile);
    localparam logic [7:0] ROW_3  = 8'(GridTop + 3 * Tile);
    localparam logic [7:0] ROW_4  = 8'(GridTop + 4 * Tile);
    localparam logic [7:0] ROW_5  = 8'(GridTop + 5 * Tile);
    localparam logic [7:0] ROW_6  = 8'(GridTop + 6 * Tile);
    localparam logic [7:0] ROW_7  = 8'(GridTop + 7 * Tile);
    localparam logic [7:0] ROW_8  = 8'(GridTop + 8 * Tile);
    localparam logic [7:0] ROW_10 = 8'(GridTop + 10 * Tile);
    localparam logic [7:0] ROW_11 = 8'(GridTop + 11 * Tile);

    // Palette indexes.
    localparam logic [4:0] COLOR_BLACK    = 5'd0;
    localparam logic [4:0] COLOR_DARK1    = 5'd1;
    localparam logic [4:0] COLOR_DARK2    = 5'd2;
    localparam logic [4:0] COLOR_BG       = 5'd3;
    localparam logic [4:0] COLOR_DARK3    = 5'd4;
    localparam logic [4:0] COLOR_LITE     = 5'd5;
    localparam logic [4:0] COLOR_WHITE    = 5'd6;
    localparam logic [4:0] COLOR_YELLOW   = 5'd7;
    localparam logic [4:0] COLOR_CYAN     = 5'd8;
    localparam logic [4:0] COLOR_GREEN    = 5'd9;
    localparam logic [4:0] COLOR_MAGENTA  = 5'd10;
    localparam logic [4:0] COLOR_RED      = 5'd11;
    localparam logic [4:0] COLOR_BLUE     = 5'd12;
    localparam logic [4:0] COLOR_SIDEBLUE = 5'd13;
    localparam logic [4:0] COLOR_GOLD     = 5'd14;
    localparam logic [4:0] COLOR_TEAL     = 5'd15;
    localparam logic [4:0] COLOR_PINK     = 5'd16;
    localparam logic [4:0] COLOR_OLIVE    = 5'd17;
    localparam logic [4:0] COLOR_PURPLE   = 5'd18;
    localparam logic [4:0] COLOR_SPARE0   = 5'd19;
    localparam logic [4:0] COLOR_SPARE1   = 5'd20;

    // Products formed in the first stage.
    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [16:0]   dx_sq;
        logic [14:0]   dy_sq;
        logic [21:0]   cx_prod;
        logic [20:0]   cy_prod;
        logic [20:0]   x25_prod;
        logic [18:0]   x3_prod;
    } meas_t;

    // Position facts used by the color selection.
    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic          in_circle;
        logic [4:0]    tile_col;
        logic [4:0]    tile_row;
        logic          dark;
        logic [4:0]    mod25;
        logic [1:0]    mod3;
    } geom_t;

    function automatic logic [RGBW-1:0] palette_rgb(input logic [CW-1:0] c);
        logic [RGBW-1:0] rgb;
        unique case (c)
            COLOR_BLACK:    rgb = 24'h000000;
            COLOR_DARK1:    rgb = 24'h343434;
            COLOR_DARK2:    rgb = 24'h666666;
            COLOR_BG:       rgb = 24'h777777;
            COLOR_DARK3:    rgb = 24'h999999;
            COLOR_LITE:     rgb = 24'hCCCCCC;
            COLOR_WHITE:    rgb = 24'hFFFFFF;
            COLOR_YELLOW:   rgb = 24'hCCCC00;
            COLOR_CYAN:     rgb = 24'h00CCCC;
            COLOR_GREEN:    rgb = 24'h00CC00;
            COLOR_MAGENTA:  rgb = 24'hCC00CC;
            COLOR_RED:      rgb = 24'hCC0000;
            COLOR_BLUE:     rgb = 24'h0000CC;
            COLOR_SIDEBLUE: rgb = 24'h587FE6;
            COLOR_GOLD:     rgb = 24'hA78019;
            COLOR_TEAL:     rgb = 24'h26AD80;
            COLOR_PINK:     rgb = 24'hD95280;
            COLOR_OLIVE:    rgb = 24'h80960E;
            COLOR_PURPLE:   rgb = 24'h8069F1;
            COLOR_SPARE0:   rgb = 24'h000000;
            COLOR_SPARE1:   rgb = 24'hD0D0D0;
            default:        rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

[design/tcpg_measure.sv]
`default_nettype none

module tcpg_measure (
    input  wire logic [tcpg_pkg::XW-1:0] x,
    input  wire logic [tcpg_pkg::YW-1:0] y,
    output tcpg_pkg::meas_t              meas
);
    import tcpg_pkg::*;

    logic signed [9:0]  dx;
    logic signed [9:0]  dy;
    logic signed [19:0] dx_prod;
    logic signed [19:0] dy_prod;
    logic [9:0]         cx;
    logic [8:0]         cy;
    logic [8:0]         x_rel3;

    always_comb
    begin
        dx      = signed'({1'b0, x}) - 10'sd160;
        dy      = signed'({2'b00, y}) - 10'sd120;
        dx_prod = dx * dx;
        dy_prod = dy * dy;
        cx      = {1'b0, x} + CX_OFFSET;
        cy      = {1'b0, y} + CY_OFFSET;
        x_rel3  = x - 9'd108;

        meas.x        = x;
        meas.y        = y;
        meas.dx_sq    = dx_prod[16:0];
        meas.dy_sq    = dy_prod[14:0];
        meas.cx_prod  = {12'b0, cx} * {10'b0, RECIP_18};
        meas.cy_prod  = {12'b0, cy} * {9'b0, RECIP_18};
        meas.x25_prod = {12'b0, x} * {9'b0, RECIP_25};
        meas.x3_prod  = {10'b0, x_rel3} * {9'b0, RECIP_3};
    end

endmodule

`default_nettype wire

[design/tcpg_reduce.sv]
`default_nettype none

module tcpg_reduce (
    input  wire tcpg_pkg::meas_t meas,
    output tcpg_pkg::geom_t      geom
);
    import tcpg_pkg::*;

    logic [17:0] dist_sq;
    logic [4:0]  q_col;
    logic [4:0]  q_row;
    logic [4:0]  q25;
    logic [7:0]  q3;
    logic [9:0]  cx;
    logic [8:0]  cy;
    logic [9:0]  col_rem;
    logic [8:0]  row_rem;
    logic [8:0]  rem25;
    logic [9:0]  rem3;
    logic [8:0]  x_rel3;

    always_comb
    begin
        dist_sq = {1'b0, meas.dx_sq} + {3'b0, meas.dy_sq};
        q_col   = meas.cx_prod[20:16];
        q_row   = meas.cy_prod[20:16];
        q25     = meas.x25_prod[20:16];
        q3      = meas.x3_prod[18:11];
        cx      = {1'b0, meas.x} + CX_OFFSET;
        cy      = {1'b0, meas.y} + CY_OFFSET;
        x_rel3  = meas.x - 9'd108;

        // Remainders: value minus quotient times divisor.
        col_rem = cx - ({q_col, 4'b0} + {4'b0, q_col, 1'b0});
        row_rem = cy - ({q_row, 4'b0} + {3'b0, q_row, 1'b0});
        rem25   = meas.x - ({q25, 4'b0} + {1'b0, q25, 3'b0} + {4'b0, q25});
        rem3    = {1'b0, x_rel3} - ({1'b0, q3, 1'b0} + {2'b0, q3});

        geom.x         = meas.x;
        geom.y         = meas.y;
        geom.in_circle = (dist_sq <= RADIUS_SQ);
        geom.tile_col  = col_rem[4:0];
        geom.tile_row  = row_rem[4:0];
        geom.dark      = q_col[0] ^ q_row[0];
        geom.mod25     = rem25[4:0];
        geom.mod3      = rem3[1:0];
    end

endmodule

`default_nettype wire

[design/tcpg_paint.sv]
`default_nettype none

module tcpg_paint (
    input  wire tcpg_pkg::geom_t         geom,
    output logic [tcpg_pkg::CW-1:0]      color
);
    import tcpg_pkg::*;

    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [XW-1:0] x_rel73;
    logic          border;
    logic          upper;
    logic          corner;
    logic [CW-1:0] side;
    logic          side_hit;
    logic [CW-1:0] inner;
    logic          in_xh;
    logic [4:0]    xh_col;

    function automatic logic [CW-1:0] bar_pick(
        input logic [XW-1:0] px,
        input logic [CW-1:0] c0, input logic [CW-1:0] c1, input logic [CW-1:0] c2,
        input logic [CW-1:0] c3, input logic [CW-1:0] c4, input logic [CW-1:0] c5);
        logic [CW-1:0] r;
        if (px < 9'd90)       r = c0;
        else if (px < 9'd125) r = c1;
        else if (px < 9'd160) r = c2;
        else if (px < 9'd195) r = c3;
        else if (px < 9'd230) r = c4;
        else                  r = c5;
        return r;
    endfunction

    always_comb
    begin
        x       = geom.x;
        y       = geom.y;
        x_rel73 = x - 9'd73;

        // Castellated background and the grey grid.
        border = (geom.tile_col == 5'd0) || (geom.tile_col == 5'd17) ||
                 (geom.tile_row == 5'd0) || (geom.tile_row == 5'd17);
        color  = (border || !geom.dark) ? COLOR_WHITE : COLOR_BLACK;
        if (x >= 9'(GridLeft) && x <= 9'(GridRight) &&
            y >= 8'(GridTop) && y <= 8'(GridBot))
        begin
            color = border ? COLOR_WHITE : COLOR_BG;
        end

        // Side bars outside the circle.
        upper    = (y < 8'(CenterY));
        corner   = (y <= 8'd55) || (y >= 8'd184);
        side_hit = 1'b0;
        side     = COLOR_BLACK;
        if (y >= 8'd22 && y <= 8'd217)
        begin
            if (x >= 9'd26 && x <= 9'd42)
            begin
                side_hit = !(x == 9'd42 && !corner);
                side     = upper ? COLOR_TEAL : COLOR_PINK;
            end
            else if (((x >= 9'd43 && x <= 9'd59) || (x >= 9'd260 && x <= 9'd276)) && corner)
            begin
                side_hit = 1'b1;
                side     = upper ? COLOR_SIDEBLUE : COLOR_GOLD;
            end
            else if (x >= 9'd277 && x <= 9'd293)
            begin
                side_hit = !(x == 9'd277 && !corner);
                side     = upper ? COLOR_OLIVE : COLOR_PURPLE;
            end
        end
        if (!geom.in_circle && side_hit && x >= 9'(GridLeft) && x <= 9'(GridRight))
        begin
            color = side;
        end

        // Inside the circle, layers later in this list paint over earlier ones.
        inner = COLOR_WHITE;
        if (y >= ROW_2 && y < ROW_7 &&
            ((x >= 9'd24 && x < 9'd108) || (x >= 9'd213 && x < 9'd296)))
        begin
            inner = COLOR_BLACK;
        end
        if (y >= ROW_1 && y < ROW_2 && x >= 9'd121 && x < 9'd199)
        begin
            inner = COLOR_BLACK;
        end
        if (x >= 9'd115 && x < 9'd117 && y >= ROW_2)
        begin
            inner = COLOR_BLACK;
        end
        if (y >= ROW_3 && y < ROW_4)
        begin
            inner = (geom.mod25 < 5'd12) ? COLOR_LITE : COLOR_BLACK;
        end
        if (y >= ROW_4 && y < ROW_6)
        begin
            inner = bar_pick(x, COLOR_YELLOW, COLOR_CYAN, COLOR_GREEN,
                             COLOR_MAGENTA, COLOR_RED, COLOR_BLUE);
        end
        if (y >= ROW_6)
        begin
            inner = COLOR_BLACK;
        end
        if (y >= ROW_6 && y < ROW_8)
        begin
            if (x >= 9'd73 && x < 9'd117)
                inner = x_rel73[2] ? COLOR_DARK2 : COLOR_BLACK;
            else if (x >= 9'd108 && x < 9'd152)
                inner = (geom.mod3 < 2'd2) ? COLOR_BLACK : COLOR_DARK2;
            else if (x >= 9'd143 && x < 9'd248)
                inner = COLOR_DARK2;
        end
        if (y >= ROW_8 && y < ROW_10)
        begin
            inner = bar_pick(x, COLOR_BLACK, COLOR_DARK1, COLOR_DARK2,
                             COLOR_DARK3, COLOR_LITE, COLOR_WHITE);
        end
        if (y >= ROW_10 && y < ROW_11)
        begin
            inner = (x >= 9'd108 && x < 9'd213) ? COLOR_BLACK : COLOR_WHITE;
            if (x >= 9'd115 && x < 9'd117)
                inner = COLOR_WHITE;
        end
        if (y >= ROW_11)
        begin
            inner = (x >= 9'd151 && x < 9'd169) ? COLOR_RED : COLOR_YELLOW;
        end

        // Crosshair: grid lines in white on black, white center lines.
        in_xh  = (y >= ROW_6 && y < ROW_7) ||
                 (x >= 9'd152 && x < 9'd168 && y >= ROW_5 && y < ROW_8);
        xh_col = (x >= 9'(GridLeft)) ? geom.tile_col : 5'd1;
        if (in_xh)
        begin
            inner = (xh_col == 5'd0 || xh_col == 5'd17) ? COLOR_WHITE : COLOR_BLACK;
            if (x == 9'(CenterX) || x == 9'(CenterX - 1) || y == 8'(CenterY))
                inner = COLOR_WHITE;
        end

        if (geom.in_circle)
        begin
            color = inner;
        end
    end

endmodule

`default_nettype wire

[design/test_card_pixel_generator.sv]
// Circle-style 320x240 test card generator. Each request carries one pixel
// coordinate and yields one response with the pixel's palette index and its
// 24-bit RGB color, red in the high byte. The block keeps no state between
// pixels and accepts a new request in every cycle unless the output stalls,
// so it keeps up with a pixel clock. The request is registered on entry, the
// first stage squares the offsets from the card center and forms the
// reciprocal products for the tile and grating divisions, the second
// finishes the circle test and the remainders, and the third picks the color
// from the layered card regions and loads the index with its RGB value into
// the output register, from which the pixel's response is offered. The
// whole pipeline advances together whenever the output register is
// empty or its response is being taken, so back pressure on the output stalls
// every stage in place without dropping or repeating a pixel. Coordinates
// off the card are still answered: the castellated border simply continues.
`default_nettype none

module test_card_pixel_generator (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [tcpg_pkg::XW-1:0]    pixel_x,
    input  wire logic [tcpg_pkg::YW-1:0]    pixel_y,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [tcpg_pkg::CW-1:0]         color_index,
    output logic [tcpg_pkg::RGBW-1:0]       pixel_rgb
);
    import tcpg_pkg::*;

    logic            advance;

    // Stage registers. Valid bits are reset; payload is not.
    logic            a_valid_reg;
    logic [XW-1:0]   a_x_reg;
    logic [YW-1:0]   a_y_reg;
    logic            b_valid_reg;
    meas_t           b_meas_reg;
    logic            c_valid_reg;
    geom_t           c_geom_reg;
    logic            out_valid_reg;
    logic [CW-1:0]   color_index_reg;
    logic [RGBW-1:0] pixel_rgb_reg;

    meas_t           b_meas_next;
    geom_t           c_geom_next;
    logic [CW-1:0]   color_index_next;

    // The pipeline moves only when the final register can take a new value.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    tcpg_measure u_measure (
        .x    (a_x_reg),
        .y    (a_y_reg),
        .meas (b_meas_next)
    );

    tcpg_reduce u_reduce (
        .meas (b_meas_reg),
        .geom (c_geom_next)
    );

    tcpg_paint u_paint (
        .geom  (c_geom_reg),
        .color (color_index_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_x_reg         <= pixel_x;
            a_y_reg         <= pixel_y;
            b_meas_reg      <= b_meas_next;
            c_geom_reg      <= c_geom_next;
            color_index_reg <= color_index_next;
            pixel_rgb_reg   <= palette_rgb(color_index_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign color_index = color_index_reg;
    assign pixel_rgb   = pixel_rgb_reg;

endmodule

`default_nettype wire
